>>> hw/rtl/lcabl_pkg.sv
// Shared types and constants for the binary-lifting LCA engine.
// No dependencies.
package lcabl_pkg;

  localparam int unsigned NODE_W          = 10;
  localparam int unsigned DEF_MAX_NODES   = 1024;
  localparam int unsigned DEF_LIFT_LEVELS = 10;

  typedef enum logic {
    KIND_ADD   = 1'b0,
    KIND_QUERY = 1'b1
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_DUP     = 2'd1,
    ST_MISSING = 2'd2
  } status_t;

  typedef struct packed {
    logic              kind;
    logic [NODE_W-1:0] node_a;
    logic [NODE_W-1:0] node_b;
  } item_t;

  typedef struct packed {
    logic [NODE_W-1:0] ancestor;
    logic [1:0]        status;
  } result_t;

endpackage

>>> hw/rtl/lcabl_queue.sv
// Two-entry input queue between the front handshake and the engine.
// Depends on lcabl_pkg.
module lcabl_queue (
  input  logic                clk,
  input  logic                rst,
  input  lcabl_pkg::item_t    wr_item,
  input  logic                wr_valid,
  output logic                wr_ready,
  output lcabl_pkg::item_t    rd_item,
  output logic                rd_valid,
  input  logic                rd_ready
);
  import lcabl_pkg::*;

  item_t      slot [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;
  logic       pop;

  assign wr_ready = (count != 2'd2);
  assign rd_valid = (count != 2'd0);
  assign rd_item  = slot[rd_ptr];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= wr_item;
    end
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule

>>> hw/rtl/lcabl_engine.sv
// Back end: tree memories, add/build sequencer, lifting query sequencer
// and result register. Depends on lcabl_pkg.
module lcabl_engine #(
  parameter int unsigned MAX_NODES   = lcabl_pkg::DEF_MAX_NODES,
  parameter int unsigned LIFT_LEVELS = lcabl_pkg::DEF_LIFT_LEVELS
) (
  input  logic                clk,
  input  logic                rst,
  input  lcabl_pkg::item_t    item,
  input  logic                item_valid,
  output logic                item_ready,
  output lcabl_pkg::result_t  result,
  output logic                result_valid,
  input  logic                result_ready,
  output logic                clearing
);
  import lcabl_pkg::*;

  localparam int unsigned IW    = $clog2(MAX_NODES);
  localparam int unsigned LW    = (LIFT_LEVELS > 1) ? $clog2(LIFT_LEVELS) : 1;
  localparam int unsigned CLR_N = (MAX_NODES > LIFT_LEVELS) ? MAX_NODES : LIFT_LEVELS;
  localparam int unsigned CW    = $clog2(CLR_N + 1);
  localparam int unsigned ANC_N = MAX_NODES * (1 << LW);

  typedef logic [IW-1:0] idx_t;
  typedef logic [LW-1:0] lvl_t;

  localparam lvl_t TOP = lvl_t'(LIFT_LEVELS - 1);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_LOOK, S_BUILD, S_LIFT, S_LIFT_W, S_TOGETHER,
    S_MEET_RD, S_MEET_W, S_CHK_RD, S_CHK_W, S_OUT
  } state_t;

  logic placed_mem [MAX_NODES];
  idx_t depth_mem  [MAX_NODES];
  idx_t anc_mem    [ANC_N];

  state_t  state;
  logic [CW-1:0] cnt;
  item_t   cur;
  idx_t    a;
  idx_t    b;
  idx_t    diff;
  lvl_t    k;
  result_t res;

  logic placed_a, placed_b;
  idx_t depth_a, depth_b;
  idx_t anc_a, anc_b;

  logic            pw_en, pw_data;
  idx_t            pw_addr;
  logic            dw_en;
  idx_t            dw_addr, dw_data;
  logic            aw_en;
  logic [IW+LW-1:0] aw_addr;
  idx_t            aw_data;
  logic [IW+LW-1:0] xa_addr, xb_addr;

  idx_t cur_a, cur_b;
  logic a_in, b_in, a_ok, b_ok;
  lvl_t jl;
  int   hi;

  assign cur_a = idx_t'(cur.node_a);
  assign cur_b = idx_t'(cur.node_b);
  assign a_in  = 32'(cur.node_a) < MAX_NODES;
  assign b_in  = 32'(cur.node_b) < MAX_NODES;
  assign a_ok  = a_in && placed_a;
  assign b_ok  = b_in && placed_b;

  assign item_ready = (state == S_IDLE);
  assign clearing   = (state == S_CLEAR);

  always_comb begin
    hi = 0;
    for (int i = 0; i < IW; i++) begin
      if (diff[i]) begin
        hi = i;
      end
    end
    if (hi > int'(LIFT_LEVELS) - 1) begin
      hi = int'(LIFT_LEVELS) - 1;
    end
    jl = lvl_t'(hi);
  end

  always_comb begin
    pw_en   = 1'b0;
    pw_addr = cur_b;
    pw_data = 1'b1;
    dw_en   = 1'b0;
    dw_addr = cur_b;
    dw_data = depth_a + idx_t'(1);
    aw_en   = 1'b0;
    aw_addr = {cur_b, lvl_t'(0)};
    aw_data = cur_a;
    xa_addr = {a, k};
    xb_addr = {b, k};
    case (state)
      S_CLEAR: begin
        pw_en   = (32'(cnt) < MAX_NODES);
        pw_addr = idx_t'(cnt);
        pw_data = (cnt == '0);
        dw_en   = (cnt == '0);
        dw_addr = '0;
        dw_data = '0;
        aw_en   = (32'(cnt) < LIFT_LEVELS);
        aw_addr = {idx_t'(0), lvl_t'(cnt)};
        aw_data = '0;
      end
      S_LOOK: begin
        xa_addr = {cur_a, lvl_t'(0)};
        if (cur.kind == KIND_ADD && a_ok && b_in && !placed_b) begin
          pw_en = 1'b1;
          dw_en = 1'b1;
          aw_en = 1'b1;
        end
      end
      S_BUILD: begin
        aw_en   = 1'b1;
        aw_addr = {b, k};
        aw_data = anc_a;
        xa_addr = {anc_a, k};
      end
      S_LIFT: begin
        xa_addr = {a, jl};
      end
      S_CHK_RD: begin
        xa_addr = {a, lvl_t'(0)};
        xb_addr = {b, lvl_t'(0)};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (pw_en) begin
      placed_mem[pw_addr] <= pw_data;
    end
    if (dw_en) begin
      depth_mem[dw_addr] <= dw_data;
    end
    if (aw_en) begin
      anc_mem[aw_addr] <= aw_data;
    end
    placed_a <= placed_mem[idx_t'(item.node_a)];
    placed_b <= placed_mem[idx_t'(item.node_b)];
    depth_a  <= depth_mem[idx_t'(item.node_a)];
    depth_b  <= depth_mem[idx_t'(item.node_b)];
    anc_a    <= anc_mem[xa_addr];
    anc_b    <= anc_mem[xb_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_CLEAR;
      cnt          <= '0;
      result_valid <= 1'b0;
    end else begin
      if (result_valid && result_ready && state != S_OUT) begin
        result_valid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          cnt <= cnt + CW'(1);
          if (32'(cnt) == CLR_N - 1) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (item_valid) begin
            cur   <= item;
            state <= S_LOOK;
          end
        end
        S_LOOK: begin
          res.ancestor <= '0;
          if (cur.kind == KIND_ADD) begin
            if (!a_ok || !b_in) begin
              res.status <= ST_MISSING;
              state      <= S_OUT;
            end else if (placed_b) begin
              res.status <= ST_DUP;
              state      <= S_OUT;
            end else begin
              res.status <= ST_OK;
              b <= cur_b;
              k <= lvl_t'(1);
              state <= (LIFT_LEVELS == 1) ? S_OUT : S_BUILD;
            end
          end else if (!a_ok || !b_ok) begin
            res.status <= ST_MISSING;
            state      <= S_OUT;
          end else begin
            res.status <= ST_OK;
            if (depth_a < depth_b) begin
              a    <= cur_b;
              b    <= cur_a;
              diff <= depth_b - depth_a;
            end else begin
              a    <= cur_a;
              b    <= cur_b;
              diff <= depth_a - depth_b;
            end
            state <= S_LIFT;
          end
        end
        S_BUILD: begin
          k <= k + lvl_t'(1);
          if (k == TOP) begin
            state <= S_OUT;
          end
        end
        S_LIFT: begin
          if (diff == '0) begin
            state <= S_TOGETHER;
          end else begin
            diff  <= diff - (idx_t'(1) << jl);
            state <= S_LIFT_W;
          end
        end
        S_LIFT_W: begin
          a     <= anc_a;
          state <= S_LIFT;
        end
        S_TOGETHER: begin
          if (a == b) begin
            res.ancestor <= NODE_W'(a);
            state        <= S_OUT;
          end else begin
            k     <= TOP;
            state <= S_MEET_RD;
          end
        end
        S_MEET_RD: begin
          state <= S_MEET_W;
        end
        S_MEET_W: begin
          if (anc_a != anc_b) begin
            a <= anc_a;
            b <= anc_b;
          end
          if (k == '0) begin
            state <= S_CHK_RD;
          end else begin
            k     <= k - lvl_t'(1);
            state <= S_MEET_RD;
          end
        end
        S_CHK_RD: begin
          state <= S_CHK_W;
        end
        S_CHK_W: begin
          if (anc_a == anc_b) begin
            res.ancestor <= NODE_W'(anc_a);
            state        <= S_OUT;
          end else begin
            k     <= TOP;
            state <= S_MEET_RD;
          end
        end
        S_OUT: begin
          if (!result_valid || result_ready) begin
            result       <= res;
            result_valid <= 1'b1;
            state        <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

>>> hw/rtl/lca_binary_lifting.sv
// Lowest common ancestor engine over a rooted tree (node 0 is the root),
// using binary lifting. Items enter a two-entry queue and are run one at a
// time by the engine. After reset a clearing pass runs before the first
// transaction is taken. An add builds one doubling entry per cycle from
// the ancestor table's registered read port. A query equalises depths by
// jumps, then runs meeting passes paced by one registered table read per
// lifting step; when 2^LIFT_LEVELS covers the tree depth one pass suffices.
// The engine takes the next transaction in the cycle after a result is
// loaded, and waits while a finished result finds the output register
// still full.
// Depends on lcabl_pkg, lcabl_queue, lcabl_engine.
module lca_binary_lifting #(
  parameter int unsigned MAX_NODES   = lcabl_pkg::DEF_MAX_NODES,
  parameter int unsigned LIFT_LEVELS = lcabl_pkg::DEF_LIFT_LEVELS
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  output logic                item_ready,
  input  lcabl_pkg::item_t    item,
  output logic                result_valid,
  input  logic                result_ready,
  output lcabl_pkg::result_t  result
);
  import lcabl_pkg::*;

  item_t q_item;
  logic  q_valid;
  logic  q_ready;
  logic  q_wr_ready;
  logic  clearing;

  assign item_ready = q_wr_ready && !clearing;

  lcabl_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_item  (item),
    .wr_valid (item_valid && !clearing),
    .wr_ready (q_wr_ready),
    .rd_item  (q_item),
    .rd_valid (q_valid),
    .rd_ready (q_ready)
  );

  lcabl_engine #(
    .MAX_NODES   (MAX_NODES),
    .LIFT_LEVELS (LIFT_LEVELS)
  ) u_engine (
    .clk          (clk),
    .rst          (rst),
    .item         (q_item),
    .item_valid   (q_valid),
    .item_ready   (q_ready),
    .result       (result),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .clearing     (clearing)
  );

endmodule

>>> hw/rtl/lcabl_checker.sv
// Port-level checks for lca_binary_lifting, bound to the top level.
// Depends on lcabl_pkg.
module lcabl_checker (
  input logic               clk,
  input logic               rst,
  input logic               item_valid,
  input logic               item_ready,
  input lcabl_pkg::item_t   item,
  input logic               result_valid,
  input logic               result_ready,
  input lcabl_pkg::result_t result
);
  import lcabl_pkg::*;

  a_rst_no_result: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result valid after reset");

  a_rst_no_take: assert property (@(posedge clk) rst |=> !item_ready)
    else $error("transaction taken during clearing pass");

  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(result))
    else $error("stalled result changed");

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && (result.status == ST_MISSING || result.status == ST_DUP)
    |-> result.ancestor == '0)
    else $error("failed transaction with non-zero ancestor");

endmodule

bind lca_binary_lifting lcabl_checker u_lcabl_checker (.*);

>>> sim/lca_binary_lifting_checker.sv
// Checker for the binary-lifting LCA engine: watches both channels, predicts
// each result from its own tree model and counts mismatches.
// Depends on lcabl_pkg.
module lca_binary_lifting_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  input  logic               item_ready,
  input  lcabl_pkg::item_t   item,
  input  logic               result_valid,
  input  logic               result_ready,
  input  lcabl_pkg::result_t result,
  output int                 fail_count,
  output int                 pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import lcabl_pkg::*;

  localparam int NODES     = DEF_MAX_NODES;
  localparam int LEVELS    = DEF_LIFT_LEVELS;
  localparam int EXP_DEPTH = 64;

  bit                is_placed [NODES] = '{0: 1'b1, default: 1'b0};
  int unsigned       depth_of  [NODES] = '{default: 0};
  logic [NODE_W-1:0] up        [NODES][LEVELS] = '{default: '0};
  result_t           expected_buf [EXP_DEPTH];
  int unsigned       wr_count = 0;
  int unsigned       rd_count = 0;
  int                fails = 0;

  function automatic int jump_for(int unsigned d);
    int k;
    k = 0;
    while (k + 1 < LEVELS && (32'd1 << (k + 1)) <= d) k++;
    return k;
  endfunction

  function automatic logic [NODE_W-1:0] common_ancestor(int a, int b);
    int t;
    while (1) begin
      if (depth_of[a] < depth_of[b]) begin
        t = a; a = b; b = t;
      end
      while (depth_of[a] != depth_of[b]) a = up[a][jump_for(depth_of[a] - depth_of[b])];
      if (a == b) return NODE_W'(a);
      for (int k = LEVELS - 1; k >= 0; k--) begin
        if (up[a][k] != up[b][k]) begin
          a = up[a][k]; b = up[b][k];
        end
      end
      if (up[a][0] == up[b][0]) return up[a][0];
    end
  endfunction

  function automatic result_t apply_item(item_t it);
    result_t r;
    int c;
    r.ancestor = '0;
    r.status   = ST_OK;
    if (it.kind == KIND_ADD) begin
      if (!is_placed[it.node_a]) r.status = ST_MISSING;
      else if (is_placed[it.node_b]) r.status = ST_DUP;
      else begin
        c = it.node_b;
        is_placed[c] = 1'b1;
        depth_of[c]  = depth_of[it.node_a] + 1;
        up[c][0]     = it.node_a;
        for (int k = 1; k < LEVELS; k++) up[c][k] = up[up[c][k-1]][k-1];
      end
    end else if (!is_placed[it.node_a] || !is_placed[it.node_b]) begin
      r.status = ST_MISSING;
    end else begin
      r.ancestor = common_ancestor(it.node_a, it.node_b);
    end
    return r;
  endfunction

  task automatic report(string what, logic [NODE_W-1:0] got, logic [NODE_W-1:0] want);
    $display("mismatch: %s got %0d expected %0d at %0t", what, got, want, $realtime);
    fails++;
  endtask

  always @(posedge clk) begin
    result_t want;
    if (!rst) begin
      if (item_valid && item_ready) begin
        expected_buf[wr_count % EXP_DEPTH] = apply_item(item);
        wr_count++;
      end
      if (result_valid && result_ready) begin
        if (wr_count == rd_count) report("unexpected transaction", result.ancestor, '0);
        else begin
          want = expected_buf[rd_count % EXP_DEPTH];
          rd_count++;
          if (result.ancestor !== want.ancestor)
            report("ancestor", result.ancestor, want.ancestor);
          if (result.status !== want.status)
            report("status", NODE_W'(result.status), NODE_W'(want.status));
        end
      end
    end
  end

  assign pending    = int'(wr_count - rd_count);
  assign fail_count = fails;
endmodule

>>> sim/lca_binary_lifting_test.sv
// Top of the LCA engine testbench: clock, reset, tree-building stimulus,
// output stalls and the verdict. Depends on lcabl_pkg, lca_binary_lifting
// and lca_binary_lifting_checker.
module lca_binary_lifting_test;
  timeunit 1ns;
  timeprecision 1ps;
  import lcabl_pkg::*;

  logic    clk;
  logic    rst;
  logic    item_valid;
  logic    item_ready;
  item_t   item;
  logic    result_valid;
  logic    result_ready;
  result_t result;
  int      fail_count;
  int      pending;
  int      cycle_count;
  bit      calm;
  bit      hold_off;

  int          tree_nodes[1024];
  int          tree_count;
  bit          used[1024];

  lca_binary_lifting i_dut (
    .clk, .rst, .item_valid, .item_ready, .item, .result_valid, .result_ready, .result
  );

  lca_binary_lifting_checker i_checker (
    .clk, .rst, .item_valid, .item_ready, .item, .result_valid, .result_ready, .result,
    .fail_count, .pending
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count > 2000000) begin
        $display("FAIL lca_binary_lifting");
        $finish;
      end
    end
  end

  task automatic send(logic k, int a, int b);
    int gap;
    if (!calm && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 18);
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_valid  <= 1'b1;
    item.kind   <= k;
    item.node_a <= a[NODE_W-1:0];
    item.node_b <= b[NODE_W-1:0];
    do @(posedge clk); while (!item_ready);
  endtask

  function automatic int any_placed();
    return tree_nodes[$urandom_range(0, tree_count - 1)];
  endfunction

  function automatic int fresh_node();
    int n;
    if (tree_count >= 1024) return any_placed();
    do n = $urandom_range(1, 1023); while (used[n]);
    return n;
  endfunction

  task automatic add_child(int p, int c);
    send(KIND_ADD, p, c);
    if (!used[c]) begin
      used[c] = 1'b1;
      tree_nodes[tree_count] = c;
      tree_count++;
    end
  endtask

  // receiver: random stall bursts, one long hold-off
  initial begin
    result_ready = 1'b0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (hold_off) result_ready <= 1'b0;
      else if (!calm && $urandom_range(0, 4) == 0) begin
        result_ready <= 1'b0;
        repeat ($urandom_range(1, 18)) @(posedge clk);
        result_ready <= 1'b1;
      end else result_ready <= 1'b1;
    end
  end

  initial begin
    int p, c, chain;
    rst = 1'b1; item_valid = 1'b0; item = '0; calm = 1'b0; hold_off = 1'b0;
    tree_nodes[0] = 0;
    tree_count = 1;
    used[0] = 1'b1;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // directed: missing nodes, duplicates, root cases, deep chain
    send(KIND_QUERY, 0, 0);
    send(KIND_QUERY, 0, 1023);
    send(KIND_ADD, 1023, 5);
    add_child(0, 1023);
    add_child(1023, 512);
    send(KIND_ADD, 0, 0);
    send(KIND_ADD, 512, 512);
    send(KIND_ADD, 0, 1023);
    send(KIND_ADD, 7, 7);
    p = 512;
    for (int i = 0; i < 12; i++) begin
      c = fresh_node(); add_child(p, c); p = c;
    end
    add_child(0, 341);
    send(KIND_QUERY, p, 341);
    send(KIND_QUERY, p, 512);
    send(KIND_QUERY, 1023, p);
    send(KIND_QUERY, p, p);
    send(KIND_QUERY, 682, 0);

    // long receiver hold-off with input still offered
    fork
      begin hold_off = 1'b1; repeat (150) @(posedge clk); hold_off = 1'b0; end
      for (int i = 0; i < 8; i++) send(KIND_QUERY, any_placed(), any_placed());
    join

    for (int i = 0; i < 680; i++) begin
      if (i == 590) calm = 1'b1;
      case ($urandom_range(0, 9))
        0, 1, 2: add_child(any_placed(), fresh_node());
        3: begin
          p = any_placed();
          chain = $urandom_range(2, 12);
          for (int j = 0; j < chain; j++) begin
            c = fresh_node(); add_child(p, c); p = c;
          end
        end
        4, 5, 6, 7: send(KIND_QUERY, any_placed(), any_placed());
        8: send(KIND_ADD, $urandom_range(0, 1023), $urandom_range(0, 1023));
        default: send(KIND_QUERY, $urandom_range(0, 1023), any_placed());
      endcase
    end
    item_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (fail_count == 0) $display("PASS lca_binary_lifting");
    else $display("FAIL lca_binary_lifting");
    $finish;
  end
endmodule
